### design/slt_pkg.sv
// Shared types and constants for the shell line tokenizer.
package slt_pkg;

  // Lexer mode between bytes
  typedef enum logic [1:0] {
    MODE_WS   = 2'd0,
    MODE_SQ   = 2'd1,
    MODE_DQ   = 2'd2,
    MODE_WORD = 2'd3
  } mode_t;

  // Held redirect character waiting for a possible second one
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_LT   = 2'd1,
    PEND_GT   = 2'd2
  } pend_t;

  // Token and status kinds
  localparam logic [3:0] KIND_WORD     = 4'd0;
  localparam logic [3:0] KIND_PIPE     = 4'd1;
  localparam logic [3:0] KIND_IN       = 4'd2;
  localparam logic [3:0] KIND_OUT      = 4'd3;
  localparam logic [3:0] KIND_HEREDOC  = 4'd4;
  localparam logic [3:0] KIND_APPEND   = 4'd5;
  localparam logic [3:0] KIND_END_OK   = 4'd6;
  localparam logic [3:0] KIND_UNCLOSED = 4'd7;
  localparam logic [3:0] KIND_TOO_LONG = 4'd8;

  // Characters of interest
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // One result record
  typedef struct packed {
    logic [3:0]  kind;
    logic [11:0] start_pos;
    logic [12:0] length;
    logic [12:0] token_total;
    logic        last;
  } tok_rec_t;

endpackage

### design/shell_line_tokenizer.sv
// Shell command line tokenizer: one byte per transfer in, token records out.
// A result record is registered into the result queue; out_* shows the queue head.
// Throughput: one byte per cycle while in_ready is high; a byte that yields two records
// still takes a single input transfer, the 4-entry result queue absorbs the second record.
// in_ready is high while the queue has room for two records.
// Reset (rst_n low, synchronous) clears line state and empties the queue.
module shell_line_tokenizer #(
  parameter int MAX_LINE = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [7:0]                in_ch,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [3:0]                out_kind,
  output logic [11:0]               out_start_pos,
  output logic [12:0]               out_length,
  output logic [12:0]               out_token_total,
  output logic                      out_last
);
  import slt_pkg::*;

  localparam int PW = $clog2(MAX_LINE + 1);
  localparam logic [PW-1:0] LINE_LIM = PW'(MAX_LINE);

  // Line state
  mode_t         mode_r,  mode_nxt;
  pend_t         pend_r,  pend_nxt;
  logic          bld_r,   bld_nxt;
  logic [PW-1:0] wstart_r, wstart_nxt;
  logic [PW-1:0] pos_r,   pos_nxt;
  logic [PW-1:0] cnt_r,   cnt_nxt;
  logic          ovf_r,   ovf_nxt;

  // Records produced by the current transfer
  tok_rec_t      res [2];
  logic [1:0]    n_res;

  // Result queue
  tok_rec_t      q_r [4];
  logic [1:0]    head_r, head_nxt;
  logic [1:0]    tail_r, tail_nxt;
  logic [2:0]    qcnt_r, qcnt_nxt;

  logic in_xfer;
  logic out_xfer;

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    return (v < LINE_LIM) ? v + 1'b1 : v;
  endfunction

  function automatic tok_rec_t mk_rec(input logic [3:0] kind, input logic [PW-1:0] start,
                                      input logic [PW-1:0] len, input logic [PW-1:0] tot,
                                      input logic last);
    tok_rec_t r;
    r.kind        = kind;
    r.start_pos   = 12'(start);
    r.length      = 13'(len);
    r.token_total = 13'(tot);
    r.last        = last;
    return r;
  endfunction

  assign in_ready  = (qcnt_r <= 3'd2);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (qcnt_r != 3'd0);
  assign out_xfer  = out_valid && out_ready;

  assign out_kind        = q_r[head_r].kind;
  assign out_start_pos   = q_r[head_r].start_pos;
  assign out_length      = q_r[head_r].length;
  assign out_token_total = q_r[head_r].token_total;
  assign out_last        = q_r[head_r].last;

  // Per-byte lexer step: next line state and up to two records
  always_comb begin
    logic [PW-1:0] cnt;
    logic [1:0]    n;
    logic          doubled;
    logic [7:0]    held_ch;
    logic [PW-1:0] pos_m1;
    cnt        = cnt_r;
    n          = 2'd0;
    doubled    = 1'b0;
    held_ch    = (pend_r == PEND_LT) ? CH_LT : CH_GT;
    pos_m1     = pos_r - 1'b1;
    mode_nxt   = mode_r;
    pend_nxt   = pend_r;
    bld_nxt    = bld_r;
    wstart_nxt = wstart_r;
    pos_nxt    = pos_r;
    ovf_nxt    = ovf_r;
    res[0]     = '0;
    res[1]     = '0;

    if (in_action) begin
      // End of line: flush held operator or open word, then status
      if (pend_r != PEND_NONE) begin
        cnt = sat_inc(cnt);
        res[n[0]] = mk_rec((pend_r == PEND_LT) ? KIND_IN : KIND_OUT, pos_m1,
                           PW'(1), cnt, 1'b0);
        n = n + 2'd1;
      end
      if (mode_r == MODE_SQ || mode_r == MODE_DQ) begin
        res[n[0]] = mk_rec(ovf_r ? KIND_TOO_LONG : KIND_UNCLOSED, '0, '0, cnt, 1'b1);
      end else begin
        if (bld_r) begin
          cnt = sat_inc(cnt);
          res[n[0]] = mk_rec(KIND_WORD, wstart_r, pos_r - wstart_r, cnt, 1'b0);
          n = n + 2'd1;
        end
        res[n[0]] = mk_rec(ovf_r ? KIND_TOO_LONG : KIND_END_OK, '0, '0, cnt, 1'b1);
      end
      n          = n + 2'd1;
      mode_nxt   = MODE_WS;
      pend_nxt   = PEND_NONE;
      bld_nxt    = 1'b0;
      wstart_nxt = '0;
      pos_nxt    = '0;
      ovf_nxt    = 1'b0;
      cnt        = '0;
    end else if (pos_r >= LINE_LIM) begin
      // Line full: byte dropped
      ovf_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + 1'b1;
      // Resolve a held '<' or '>'
      if (pend_r != PEND_NONE) begin
        pend_nxt = PEND_NONE;
        cnt = sat_inc(cnt);
        if (in_ch == held_ch) begin
          doubled = 1'b1;
          res[n[0]] = mk_rec((pend_r == PEND_LT) ? KIND_HEREDOC : KIND_APPEND, pos_m1,
                             PW'(2), cnt, 1'b0);
        end else begin
          res[n[0]] = mk_rec((pend_r == PEND_LT) ? KIND_IN : KIND_OUT, pos_m1,
                             PW'(1), cnt, 1'b0);
        end
        n = n + 2'd1;
      end
      if (!doubled) begin
        priority if (mode_r == MODE_SQ) begin
          if (in_ch == CH_SQUOT) mode_nxt = MODE_WORD;
        end else if (mode_r == MODE_DQ) begin
          if (in_ch == CH_DQUOT) mode_nxt = MODE_WORD;
        end else if (in_ch == CH_PIPE || in_ch == CH_LT || in_ch == CH_GT) begin
          // Operator ends any open word
          if (bld_r) begin
            cnt = sat_inc(cnt);
            res[n[0]] = mk_rec(KIND_WORD, wstart_r, pos_r - wstart_r, cnt, 1'b0);
            n = n + 2'd1;
            bld_nxt = 1'b0;
          end
          mode_nxt = MODE_WS;
          if (in_ch == CH_PIPE) begin
            cnt = sat_inc(cnt);
            res[n[0]] = mk_rec(KIND_PIPE, pos_r, PW'(1), cnt, 1'b0);
            n = n + 2'd1;
          end else begin
            pend_nxt = (in_ch == CH_LT) ? PEND_LT : PEND_GT;
          end
        end else if (in_ch == CH_SQUOT || in_ch == CH_DQUOT) begin
          if (!bld_r) begin
            bld_nxt    = 1'b1;
            wstart_nxt = pos_r;
          end
          mode_nxt = (in_ch == CH_SQUOT) ? MODE_SQ : MODE_DQ;
        end else if (in_ch == CH_SPACE || in_ch == CH_TAB) begin
          if (bld_r) begin
            cnt = sat_inc(cnt);
            res[n[0]] = mk_rec(KIND_WORD, wstart_r, pos_r - wstart_r, cnt, 1'b0);
            n = n + 2'd1;
            bld_nxt  = 1'b0;
            mode_nxt = MODE_WS;
          end
        end else begin
          if (!bld_r) begin
            bld_nxt    = 1'b1;
            wstart_nxt = pos_r;
          end
          mode_nxt = MODE_WORD;
        end
      end
    end
    cnt_nxt = cnt;
    n_res   = n;
  end

  // Queue pointer bookkeeping
  always_comb begin
    logic [1:0] push;
    push     = in_xfer ? n_res : 2'd0;
    tail_nxt = tail_r + push;
    head_nxt = head_r + {1'b0, out_xfer};
    qcnt_nxt = qcnt_r + {1'b0, push} - {2'b0, out_xfer};
  end

  // Control and line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_WS;
      pend_r   <= PEND_NONE;
      bld_r    <= 1'b0;
      wstart_r <= '0;
      pos_r    <= '0;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
      qcnt_r   <= '0;
    end else begin
      if (in_xfer) begin
        mode_r   <= mode_nxt;
        pend_r   <= pend_nxt;
        bld_r    <= bld_nxt;
        wstart_r <= wstart_nxt;
        pos_r    <= pos_nxt;
        cnt_r    <= cnt_nxt;
        ovf_r    <= ovf_nxt;
      end
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      qcnt_r <= qcnt_nxt;
    end
  end

  // Queue payload, no reset
  always_ff @(posedge clk) begin
    if (in_xfer && n_res != 2'd0) q_r[tail_r] <= res[0];
    if (in_xfer && n_res == 2'd2) q_r[tail_r + 2'd1] <= res[1];
  end

endmodule
